// File: rtl/fba_pkg.sv
// Shared types and constants of the block allocator.
package fba_pkg;

  localparam int DATA_W = 16;

  localparam logic [DATA_W-1:0] LINK_FREE = 16'h0000;
  localparam logic [DATA_W-1:0] LINK_END  = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_READ     = 2'd1,
    OP_ALLOC    = 2'd2,
    OP_FIND_END = 2'd3
  } fba_op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_RANGE    = 2'd2,
    ST_TOO_LONG = 2'd3
  } fba_status_t;

  typedef struct packed {
    fba_op_t           operation;
    logic [DATA_W-1:0] block_index;
    logic [DATA_W-1:0] entry_value;
  } fba_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_block;
    fba_status_t       status;
  } fba_out_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_READ,
    S_SCAN,
    S_LINK,
    S_MARK,
    S_WALK,
    S_RESPOND
  } fba_state_t;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_LOAD,
    ACT_CLEAR,
    ACT_WRITE,
    ACT_READ,
    ACT_SCAN_START,
    ACT_SCAN_STEP,
    ACT_LINK,
    ACT_MARK_END,
    ACT_WALK_START,
    ACT_WALK_STEP
  } fba_act_t;

  typedef enum logic [3:0] {
    RES_HOLD,
    RES_ZERO_OK,
    RES_ZERO_RANGE,
    RES_ZERO_NOFREE,
    RES_ZERO_LONG,
    RES_RDATA_OK,
    RES_K_OK,
    RES_CUR_OK,
    RES_CUR_RANGE
  } fba_res_t;

  typedef struct packed {
    fba_act_t act;
    fba_res_t res;
  } fba_cmd_t;

  typedef struct packed {
    logic    clr_last;
    logic    idx_bad;
    fba_op_t op;
    logic    zero_hit;
    logic    scan_last;
    logic    link_end;
    logic    link_bad;
    logic    walk_last;
  } fba_stat_t;

endpackage

// File: rtl/fba_ram.sv
// Generic single write port, single read port RAM with registered read.
module fba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/fba_dpath.sv
// Datapath of the block allocator: operand registers, scan and walk counters, link table.
module fba_dpath #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  fba_pkg::fba_in_t   in_item,
  input  fba_pkg::fba_cmd_t  cmd,
  output fba_pkg::fba_stat_t stat,
  output fba_pkg::fba_out_t  res
);
  import fba_pkg::*;

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam logic [DATA_W:0]  NUM_EXT = (DATA_W+1)'(NUM_BLOCKS);
  localparam logic [IDX_W-1:0] LAST    = IDX_W'(NUM_BLOCKS - 1);

  logic [DATA_W-1:0] idx_r, idx_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  fba_op_t           op_r, op_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [IDX_W-1:0]  cur_r, cur_nxt;
  logic [IDX_W-1:0]  steps_r, steps_nxt;
  fba_out_t          res_r, res_nxt;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  logic [IDX_W-1:0]  idx_a;
  logic [IDX_W-1:0]  rd_a;

  assign idx_a = idx_r[IDX_W-1:0];
  assign rd_a  = ram_rdata[IDX_W-1:0];

  fba_ram #(
    .WIDTH(DATA_W),
    .DEPTH(NUM_BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    stat.clr_last  = (k_r == LAST);
    stat.idx_bad   = ({1'b0, idx_r} >= NUM_EXT);
    stat.op        = op_r;
    stat.zero_hit  = (ram_rdata == LINK_FREE);
    stat.scan_last = (k_r == LAST);
    stat.link_end  = (ram_rdata == LINK_END);
    stat.link_bad  = ({1'b0, ram_rdata} >= NUM_EXT);
    stat.walk_last = (steps_r == LAST);
  end

  always_comb begin
    idx_nxt   = idx_r;
    val_nxt   = val_r;
    op_nxt    = op_r;
    k_nxt     = k_r;
    cur_nxt   = cur_r;
    steps_nxt = steps_r;
    ram_we    = 1'b0;
    ram_waddr = k_r;
    ram_wdata = LINK_FREE;
    ram_raddr = k_r;
    case (cmd.act)
      ACT_LOAD: begin
        idx_nxt = in_item.block_index;
        val_nxt = in_item.entry_value;
        op_nxt  = in_item.operation;
      end
      ACT_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = k_r;
        ram_wdata = LINK_FREE;
        k_nxt     = (k_r == LAST) ? '0 : k_r + 1'b1;
      end
      ACT_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = idx_a;
        ram_wdata = val_r;
      end
      ACT_READ: begin
        ram_raddr = idx_a;
      end
      ACT_SCAN_START: begin
        ram_raddr = '0;
        k_nxt     = '0;
      end
      ACT_SCAN_STEP: begin
        ram_raddr = k_r + 1'b1;
        k_nxt     = k_r + 1'b1;
      end
      ACT_LINK: begin
        ram_we    = 1'b1;
        ram_waddr = idx_a;
        ram_wdata = DATA_W'(k_r);
      end
      ACT_MARK_END: begin
        ram_we    = 1'b1;
        ram_waddr = k_r;
        ram_wdata = LINK_END;
      end
      ACT_WALK_START: begin
        ram_raddr = idx_a;
        cur_nxt   = idx_a;
        steps_nxt = '0;
      end
      ACT_WALK_STEP: begin
        ram_raddr = rd_a;
        cur_nxt   = rd_a;
        steps_nxt = steps_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    res_nxt = res_r;
    case (cmd.res)
      RES_ZERO_OK:     res_nxt = '{result_block: '0, status: ST_OK};
      RES_ZERO_RANGE:  res_nxt = '{result_block: '0, status: ST_RANGE};
      RES_ZERO_NOFREE: res_nxt = '{result_block: '0, status: ST_NO_FREE};
      RES_ZERO_LONG:   res_nxt = '{result_block: '0, status: ST_TOO_LONG};
      RES_RDATA_OK:    res_nxt = '{result_block: ram_rdata, status: ST_OK};
      RES_K_OK:        res_nxt = '{result_block: DATA_W'(k_r), status: ST_OK};
      RES_CUR_OK:      res_nxt = '{result_block: DATA_W'(cur_r), status: ST_OK};
      RES_CUR_RANGE:   res_nxt = '{result_block: DATA_W'(cur_r), status: ST_RANGE};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
    end else begin
      k_r <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    val_r   <= val_nxt;
    op_r    <= op_nxt;
    cur_r   <= cur_nxt;
    steps_r <= steps_nxt;
    res_r   <= res_nxt;
  end

  assign res = res_r;

`ifndef SYNTHESIS
  a_scan_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.act == ACT_SCAN_STEP) |-> (k_r != LAST && !stat.zero_hit))
    else $error("free-block scan stepped past the last entry or a free hit");

  a_walk_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.act == ACT_WALK_STEP) |-> (!stat.walk_last && !stat.link_bad && !stat.link_end))
    else $error("chain walk followed a terminal or bad link");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.act == ACT_WALK_START || cmd.act == ACT_SCAN_START) |-> !stat.idx_bad)
    else $error("table operation started on an out-of-range index");

  a_steps_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.act == ACT_WALK_STEP) |=> (steps_r == $past(steps_r) + 1'b1))
    else $error("walk step counter failed to advance");
`endif

endmodule

// File: rtl/fba_ctrl.sv
// Controller of the block allocator: sequences clear, command dispatch, read, write, scan, link and walk.
module fba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  fba_pkg::fba_stat_t stat,
  output fba_pkg::fba_cmd_t  cmd,
  output logic               busy,
  output logic               out_valid
);
  import fba_pkg::*;

  fba_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR:    if (stat.clr_last) state_nxt = S_IDLE;
      S_IDLE:     if (start) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        if (stat.idx_bad) begin
          state_nxt = S_RESPOND;
        end else begin
          case (stat.op)
            OP_WRITE: state_nxt = S_RESPOND;
            OP_READ:  state_nxt = S_READ;
            OP_ALLOC: state_nxt = S_SCAN;
            default:  state_nxt = S_WALK;
          endcase
        end
      end
      S_READ:     state_nxt = S_RESPOND;
      S_SCAN: begin
        if (stat.zero_hit) begin
          state_nxt = S_LINK;
        end else if (stat.scan_last) begin
          state_nxt = S_RESPOND;
        end
      end
      S_LINK:     state_nxt = S_MARK;
      S_MARK:     state_nxt = S_RESPOND;
      S_WALK: begin
        if (stat.link_end || stat.link_bad || stat.walk_last) begin
          state_nxt = S_RESPOND;
        end
      end
      S_RESPOND:  state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.act = ACT_NONE;
    cmd.res = RES_HOLD;
    case (state_r)
      S_CLEAR: cmd.act = ACT_CLEAR;
      S_IDLE:  if (start) cmd.act = ACT_LOAD;
      S_DISPATCH: begin
        if (stat.idx_bad) begin
          cmd.res = RES_ZERO_RANGE;
        end else begin
          case (stat.op)
            OP_WRITE: begin
              cmd.act = ACT_WRITE;
              cmd.res = RES_ZERO_OK;
            end
            OP_READ:  cmd.act = ACT_READ;
            OP_ALLOC: cmd.act = ACT_SCAN_START;
            default:  cmd.act = ACT_WALK_START;
          endcase
        end
      end
      S_READ: cmd.res = RES_RDATA_OK;
      S_SCAN: begin
        if (stat.zero_hit) begin
          cmd.act = ACT_NONE;
        end else if (stat.scan_last) begin
          cmd.res = RES_ZERO_NOFREE;
        end else begin
          cmd.act = ACT_SCAN_STEP;
        end
      end
      S_LINK: cmd.act = ACT_LINK;
      S_MARK: begin
        cmd.act = ACT_MARK_END;
        cmd.res = RES_K_OK;
      end
      S_WALK: begin
        if (stat.link_end) begin
          cmd.res = RES_CUR_OK;
        end else if (stat.link_bad) begin
          cmd.res = RES_CUR_RANGE;
        end else if (stat.walk_last) begin
          cmd.res = RES_ZERO_LONG;
        end else begin
          cmd.act = ACT_WALK_STEP;
        end
      end
      default: ;
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_RESPOND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a command in progress");

  a_start_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == S_DISPATCH && busy))
    else $error("accepted command was not dispatched");
`endif

endmodule

// File: rtl/fat_block_allocator_unit.sv
// Top level of the file allocation table block allocator.
// Commands are taken when start is high and busy is low; each command gives exactly one result,
// shown on out_item for a single cycle while out_valid is high, and it cannot be held off.
// After reset the link table is cleared to all free, one entry per cycle, so busy stays high
// until the clear has reached the last entry, and no command is taken before then. The table is
// one memory with a single read port, and every command visits it one entry per cycle: an
// allocation scans it from entry 0 for the first free entry, and a chain-end search follows the
// links from the given index. An out-of-range index returns a range status without visiting the
// table. busy falls in the cycle after out_valid.
module fat_block_allocator_unit #(
  parameter int NUM_BLOCKS = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  fba_pkg::fba_in_t in_item,
  output logic             out_valid,
  output fba_pkg::fba_out_t out_item
);
  import fba_pkg::*;

  fba_cmd_t  cmd;
  fba_stat_t stat;

  fba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy),
    .out_valid(out_valid)
  );

  fba_dpath #(
    .NUM_BLOCKS(NUM_BLOCKS)
  ) u_dpath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_item(in_item),
    .cmd    (cmd),
    .stat   (stat),
    .res    (out_item)
  );

endmodule
